// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ----- src/stg_pkg.sv -----
package stg_pkg;

	localparam int FRAME_COUNT_W = 7;
	localparam int SAMPLE_W      = 16;
	localparam int INDEX_W       = 32;
	localparam int PERIOD_W      = 12;
	localparam int VOLUME_W      = 15;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 15;

	// turn fraction seen by the sine unit, angle magnitude and cordic datapath
	localparam int TURN_W  = 32;
	localparam int ANGLE_W = 31;
	localparam int CW      = 34;
	localparam int ATAN_W  = 31;
	localparam int SHIFT_W = 5;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 12'd187;
	localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 12'd2;
	localparam logic [VOLUME_W-1:0] VOLUME_RESET = 15'd2000;

	localparam logic [31:0]          PI_Q30          = 32'd3373259426;
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [32:0]   TURN_QUARTER    = 33'sd1073741824;
	localparam logic signed [32:0]   TURN_HALF       = 33'sd2147483648;

	localparam logic signed [SAMPLE_W:0] SAMPLE_MAX = 17'sd32767;
	localparam logic [SAMPLE_W:0]        NEG_LIMIT  = 17'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVE_PERIOD = 2'd0,
		REG_TONE_VOLUME = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ANGLE,
		ST_LOAD,
		ST_ROTATE,
		ST_SCALE,
		ST_EMIT
	} state_t;

	// arctangent of 2^-i in q2.30, truncated
	function automatic logic [ATAN_W-1:0] atan_q30(input logic [SHIFT_W-1:0] i);
		logic [ATAN_W-1:0] r;
		case (i)
			5'd0:    r = 31'd843314856;
			5'd1:    r = 31'd497837829;
			5'd2:    r = 31'd263043836;
			5'd3:    r = 31'd133525158;
			5'd4:    r = 31'd67021686;
			5'd5:    r = 31'd33543515;
			5'd6:    r = 31'd16775850;
			5'd7:    r = 31'd8388437;
			5'd8:    r = 31'd4194282;
			5'd9:    r = 31'd2097149;
			5'd10:   r = 31'd1048575;
			5'd11:   r = 31'd524287;
			5'd12:   r = 31'd262143;
			5'd13:   r = 31'd131071;
			5'd14:   r = 31'd65535;
			5'd15:   r = 31'd32767;
			5'd16:   r = 31'd16383;
			5'd17:   r = 31'd8191;
			5'd18:   r = 31'd4095;
			5'd19:   r = 31'd2047;
			5'd20:   r = 31'd1023;
			5'd21:   r = 31'd511;
			5'd22:   r = 31'd255;
			5'd23:   r = 31'd127;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- src/stg_if.sv -----
interface stg_req_if;
	import stg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [FRAME_COUNT_W-1:0] frame_count;

	modport source(output valid, output frame_count, input ready);
	modport sink(input valid, input frame_count, output ready);
endinterface

interface stg_frame_if;
	import stg_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic [INDEX_W-1:0]         frame_index;
	logic                       burst_last;

	modport source(output valid, output left_sample, output right_sample,
		output frame_index, output burst_last, input ready);
	modport sink(input valid, input left_sample, input right_sample,
		input frame_index, input burst_last, output ready);
endinterface

// ----- src/sine_tone_generator_unit.sv -----
// sine tone generator, direct digital synthesis with an iterative cordic
// req: one request carries frame_count; it asks for that many stereo frames
//   (0 gives none, above MAX_BURST is cut to MAX_BURST)
// frames: one result per frame, same sample on left and right, the running
//   frame counter and a flag on the last frame of the request
// config: cfg_we/cfg_idx/cfg_data, index 0 wave_period, 1 tone_volume;
//   a period write starts a restoring divider for the phase step once the
//   block is idle, req.ready stays low until it is done
// frame steps: each frame runs angle multiply, cordic load, SINE_STEPS shared
//   cordic iterations, volume multiply and the saturate/emit step; the frames
//   of a burst are computed one after another on the single cordic datapath
// one request is worked on at a time; req.ready is high only when idle
// stall: a finished frame sits in the output register while the next one
//   is computed; the block waits in the emit step until that register frees
// reset: phase and frame counter zero, period 187, volume 2000, phase step
//   floor(2^PHASE_BITS/187), no frame pending
`include "assert_macros.svh"

module sine_tone_generator_unit #(
	parameter int PHASE_BITS = 32,
	parameter int MAX_BURST  = 64,
	parameter int SINE_STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [stg_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [stg_pkg::CFG_DATA_W-1:0]  cfg_data,
	stg_req_if.sink                         req,
	stg_frame_if.source                     frames
);
	import stg_pkg::*;

	localparam int FL_W      = $clog2(MAX_BURST + 1);
	localparam int ITER_W    = (SINE_STEPS > 1) ? $clog2(SINE_STEPS) : 1;
	localparam int DIV_CNT_W = $clog2(PHASE_BITS + 1);
	localparam logic [PHASE_BITS-1:0] STEP_RESET =
		PHASE_BITS'((65'd1 << PHASE_BITS) / 65'd187);
	localparam logic [ITER_W-1:0]        ITER_LAST = ITER_W'(SINE_STEPS - 1);
	localparam logic [DIV_CNT_W-1:0]     DIV_TOP   = DIV_CNT_W'(PHASE_BITS);
	localparam logic [FRAME_COUNT_W-1:0] BURST_MAX = FRAME_COUNT_W'(MAX_BURST);

	state_t state_q, state_d;

	logic [PERIOD_W-1:0]   period_q;
	logic [VOLUME_W-1:0]   volume_q;
	logic                  div_pend_q;
	logic [PHASE_BITS-1:0] step_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [INDEX_W-1:0]    frame_cnt_q;
	logic [FL_W-1:0]       frames_left_q;

	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic [PERIOD_W-1:0]   rem_q;
	logic [PHASE_BITS-1:0] quo_q;

	logic [ANGLE_W-1:0]    ang_q;
	logic                  ang_neg_q;
	logic signed [CW-1:0]  x_q, y_q, z_q;
	logic [ITER_W-1:0]     iter_q;
	logic                  y_neg_q;
	logic [TURN_W+VOLUME_W-1:0] scl_q;

	logic                  out_vld_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [INDEX_W-1:0]    index_q;
	logic                  last_q;

	// sequencer controls
	logic req_rdy, accept, div_init, div_run, div_done, ang_en, load_en, rot_en;
	logic scale_en, emit_en;
	logic out_free;

	assign out_free = !out_vld_q || frames.ready;
	assign div_done = (div_cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		req_rdy  = 1'b0;
		div_init = 1'b0;
		div_run  = 1'b0;
		ang_en   = 1'b0;
		load_en  = 1'b0;
		rot_en   = 1'b0;
		scale_en = 1'b0;
		emit_en  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (div_pend_q) begin
					div_init = 1'b1;
					state_d  = ST_DIV;
				end else begin
					req_rdy = 1'b1;
					if (req.valid && req.frame_count != '0) begin
						state_d = ST_ANGLE;
					end
				end
			end
			ST_DIV: begin
				div_run = 1'b1;
				// a newer period write restarts the division from idle
				if (div_pend_q || div_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_ANGLE: begin
				ang_en  = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				load_en = 1'b1;
				state_d = ST_ROTATE;
			end
			ST_ROTATE: begin
				rot_en = 1'b1;
				if (iter_q == ITER_LAST) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				scale_en = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit_en = 1'b1;
					state_d = (frames_left_q == FL_W'(1)) ? ST_IDLE : ST_ANGLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign accept    = req_rdy && req.valid;
	assign req.ready = req_rdy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= PERIOD_RESET;
			volume_q   <= VOLUME_RESET;
			div_pend_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == REG_WAVE_PERIOD) begin
				period_q   <= cfg_data[PERIOD_W-1:0];
				div_pend_q <= 1'b1;
			end else if (div_init) begin
				div_pend_q <= 1'b0;
			end
			if (cfg_we && cfg_idx == REG_TONE_VOLUME) begin
				volume_q <= cfg_data[VOLUME_W-1:0];
			end
		end
	end

	// restoring divider: 2^PHASE_BITS / max(period, PERIOD_MIN), one quotient bit a cycle
	logic [PERIOD_W-1:0] divisor;
	logic [PERIOD_W:0]   trial;
	logic                q_bit;

	assign divisor = (period_q < PERIOD_MIN) ? PERIOD_MIN : period_q;
	assign trial   = {rem_q, (div_cnt_q == DIV_TOP)};
	assign q_bit   = (trial >= {1'b0, divisor});

	always_ff @(posedge clk) begin
		if (div_init) begin
			div_cnt_q <= DIV_TOP;
			rem_q     <= '0;
			quo_q     <= '0;
		end else if (div_run) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			rem_q     <= q_bit ? PERIOD_W'(trial - {1'b0, divisor}) : trial[PERIOD_W-1:0];
			quo_q     <= {quo_q[PHASE_BITS-2:0], q_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (div_run && div_done && !div_pend_q) begin
			step_q <= {quo_q[PHASE_BITS-2:0], q_bit};
		end
	end

	// phase, frame counter and burst count
	logic [FRAME_COUNT_W-1:0] count_sat;
	assign count_sat = (req.frame_count > BURST_MAX) ? BURST_MAX : req.frame_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			frame_cnt_q   <= '0;
			frames_left_q <= '0;
		end else begin
			if (accept) begin
				frames_left_q <= FL_W'(count_sat);
			end else if (emit_en) begin
				frames_left_q <= frames_left_q - FL_W'(1);
			end
			if (emit_en) begin
				phase_q     <= phase_q + step_q;
				frame_cnt_q <= frame_cnt_q + INDEX_W'(1);
			end
		end
	end

	// turn fraction as 32 bits
	logic [TURN_W-1:0] turn;
	generate
		if (PHASE_BITS >= TURN_W) begin : g_turn_top
			assign turn = phase_q[PHASE_BITS-1 -: TURN_W];
		end else begin : g_turn_pad
			assign turn = {phase_q, {(TURN_W-PHASE_BITS){1'b0}}};
		end
	endgenerate

	// fold into the first and fourth quadrant, then scale by pi
	logic signed [32:0]       s_ext, s_fold;
	logic [ANGLE_W-1:0]       s_mag;
	logic [ANGLE_W+TURN_W-1:0] ang_prod;

	always_comb begin
		s_ext = {turn[TURN_W-1], turn};
		if (s_ext > TURN_QUARTER) begin
			s_fold = TURN_HALF - s_ext;
		end else if (s_ext < -TURN_QUARTER) begin
			s_fold = -TURN_HALF - s_ext;
		end else begin
			s_fold = s_ext;
		end
		s_mag = s_fold[32] ? ANGLE_W'(-s_fold) : ANGLE_W'(s_fold);
	end

	assign ang_prod = (ANGLE_W+TURN_W)'(s_mag) * (ANGLE_W+TURN_W)'(PI_Q30);

	always_ff @(posedge clk) begin
		if (ang_en) begin
			ang_q     <= ang_prod[ANGLE_W+TURN_W-2 -: ANGLE_W];
			ang_neg_q <= s_fold[32];
		end
	end

	// shared cordic datapath, one rotation a cycle
	logic signed [CW-1:0] dx, dy, at, z_init;

	assign dx     = y_q >>> iter_q;
	assign dy     = x_q >>> iter_q;
	assign at     = CW'(atan_q30(SHIFT_W'(iter_q)));
	assign z_init = ang_neg_q ? -CW'(ang_q) : CW'(ang_q);

	always_ff @(posedge clk) begin
		if (load_en) begin
			x_q    <= CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= z_init;
			iter_q <= '0;
		end else if (rot_en) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
			iter_q <= iter_q + ITER_W'(1);
		end
	end

	// volume scaling
	logic [TURN_W-1:0] y_abs;
	assign y_abs = y_q[CW-1] ? TURN_W'(-y_q) : TURN_W'(y_q);

	always_ff @(posedge clk) begin
		if (scale_en) begin
			scl_q   <= (TURN_W+VOLUME_W)'(y_abs) * (TURN_W+VOLUME_W)'(volume_q);
			y_neg_q <= y_q[CW-1];
		end
	end

	// truncate toward zero, then saturate
	logic [SAMPLE_W:0]          s_abs;
	logic signed [SAMPLE_W-1:0] sample_d;

	always_comb begin
		s_abs = scl_q[30 +: SAMPLE_W+1];
		if (y_neg_q) begin
			sample_d = (s_abs > NEG_LIMIT) ? SAMPLE_W'(-NEG_LIMIT) : SAMPLE_W'(-s_abs);
		end else begin
			sample_d = (s_abs > SAMPLE_MAX) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(s_abs);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_en) begin
			out_vld_q <= 1'b1;
		end else if (frames.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			sample_q <= sample_d;
			index_q  <= frame_cnt_q;
			last_q   <= (frames_left_q == FL_W'(1));
		end
	end

	assign frames.valid        = out_vld_q;
	assign frames.left_sample  = sample_q;
	assign frames.right_sample = sample_q;
	assign frames.frame_index  = index_q;
	assign frames.burst_last   = last_q;

	`ASSERT_IMPL(a_idle_no_burst, clk, arst_n, req.ready, frames_left_q == '0 && !div_pend_q)
	`ASSERT_IMPL(a_emit_has_frame, clk, arst_n, emit_en, frames_left_q != '0)
	`ASSERT_NEXT(a_cnt_advance, clk, arst_n, emit_en, frame_cnt_q == $past(frame_cnt_q) + 32'd1)
	`ASSERT_NEXT(a_step_hold, clk, arst_n, state_q != ST_DIV, step_q == $past(step_q))

endmodule
